### design/ft3d_pkg.sv
// ----------------------------------------------------------------------------
// Frame transform package
// Operation codes and common payload types for the 3D frame transform.
// ----------------------------------------------------------------------------
package ft3d_pkg;

    typedef logic [1:0]         op_t;
    typedef logic signed [31:0] vec_t;

    localparam op_t OP_BUILD   = 2'd0;
    localparam op_t OP_FORWARD = 2'd1;
    localparam op_t OP_INVERSE = 2'd2;

endpackage

### design/frame_transform_3d.sv
// ----------------------------------------------------------------------------
// 3D frame transform
// Builds an orthonormal 3x3 frame from an axis and applies it or its
// transpose to vectors.
// ----------------------------------------------------------------------------
// A build item normalizes the axis, stores it as row 0 and derives rows 1 and
// 2 by a reciprocal root and cross products; its result is the normalized
// axis, or zeros with status set when the axis is zero (matrix untouched).
// A forward item returns M*v and an inverse item returns the transpose times
// v; convert items are meaningful only after a successful build. The block
// takes one item at a time. A convert runs nine products through the single
// multiplier. A build runs two square roots and five divides at one result
// bit per cycle, which dominate, plus the axis normalizing shift. A zero axis
// is rejected in the magnitude step, before any shift or root. A finished
// result waits in the output register and the next item can be accepted
// meanwhile; a result finished while the previous one is still stalled holds
// the block until the output register frees up.
module frame_transform_3d #(
    parameter int VEC_FRAC_BITS = 20,
    parameter int MAT_FRAC_BITS = 30
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  ft3d_pkg::op_t   operation,
    input  ft3d_pkg::vec_t  vec_z,
    input  ft3d_pkg::vec_t  vec_y,
    input  ft3d_pkg::vec_t  vec_x,
    output logic            result_valid,
    input  logic            result_stall,
    output ft3d_pkg::vec_t  out_z,
    output ft3d_pkg::vec_t  out_y,
    output ft3d_pkg::vec_t  out_x,
    output logic            status
);
    import ft3d_pkg::*;

    typedef logic signed [33:0] wk_t;
    typedef logic signed [67:0] prod_t;
    typedef logic signed [69:0] acc_t;

    typedef enum logic [4:0] {
        S_IDLE, S_CMUL, S_CACC, S_ABS, S_NORM, S_SQ, S_SQACC, S_SQRT, S_DIV,
        S_RSAVE, S_ESTART, S_ESAVE, S_CSQ, S_QROOT, S_R2SAVE, S_TSTART,
        S_TSAVE, S_PMUL, S_PRND, S_DONE
    } state_t;

    localparam int   VD     = MAT_FRAC_BITS - VEC_FRAC_BITS;
    localparam int   VDP    = (VD > 0) ? VD : 0;
    localparam int   VDN    = (VD < 0) ? -VD : 0;
    localparam acc_t HALF_V = (70'sd1 <<< VDP) >>> 1;
    localparam acc_t HALF_M = 70'sd1 <<< (MAT_FRAC_BITS - 1);
    localparam acc_t ONE_M  = 70'sd1 <<< MAT_FRAC_BITS;
    localparam acc_t NEG_ONE_M = -ONE_M;
    localparam logic [63:0] ONE2 = 64'd1 << (2 * MAT_FRAC_BITS);
    localparam logic [33:0] THR  = 34'((64'd4 << MAT_FRAC_BITS) / 5);
    localparam acc_t I32_MAX = 70'sd2147483647;
    localparam acc_t I32_MIN = -70'sd2147483648;

    function automatic vec_t sat32(input acc_t x);
        if (x > I32_MAX) begin
            return vec_t'(I32_MAX[31:0]);
        end
        if (x < I32_MIN) begin
            return vec_t'(I32_MIN[31:0]);
        end
        return x[31:0];
    endfunction

    function automatic vec_t clamp_m(input acc_t x);
        if (x > ONE_M) begin
            return ONE_M[31:0];
        end
        if (x < NEG_ONE_M) begin
            return NEG_ONE_M[31:0];
        end
        return x[31:0];
    endfunction

    function automatic vec_t to_vec(input wk_t e);
        acc_t x;
        x = 70'(e);
        if (VD > 0) begin
            x = (x + HALF_V) >>> VDP;
        end
        else begin
            x = x <<< VDN;
        end
        return sat32(x);
    endfunction

    function automatic logic [33:0] abs_wk(input wk_t x);
        return x[33] ? 34'(-x) : 34'(x);
    endfunction

    state_t      state_reg, state_next, ret_reg, ret_next;
    op_t         op_reg, op_next;
    vec_t        vin_reg [3];
    vec_t        vin_next [3];
    logic [31:0] mag_reg [3];
    logic [31:0] mag_next [3];
    wk_t         e_reg [3];
    wk_t         e_next [3];
    wk_t         ta_reg, ta_next, tb_reg, tb_next;
    vec_t        res_reg [3];
    vec_t        res_next [3];
    logic        stat_reg, stat_next;
    logic [1:0]  i_reg, i_next, j_reg, j_next, k_reg, k_next;
    acc_t        acc_reg, acc_next;
    prod_t       prod_reg;
    logic [63:0] num_reg, num_next;
    logic [65:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next, den_reg, den_next;
    logic [4:0]  cnt_reg, cnt_next;
    vec_t        oz_reg, oz_next, oy_reg, oy_next, ox_reg, ox_next;
    logic        ostat_reg, ostat_next, ovalid_reg, ovalid_next;

    vec_t        mat_reg [9];
    logic        mat_we;
    logic [3:0]  mat_wa;
    vec_t        mat_wd;
    logic [3:0]  mat_ridx;

    wk_t         mul_a, mul_b;
    logic        br_a;
    wk_t         cterm, dterm;
    logic [65:0] step_rs, step_op;
    logic [66:0] step_diff;
    logic        step_fit;

    // Branch A zeroes column x of row 1; branch B zeroes column y of row 2.
    assign br_a  = abs_wk(e_reg[2]) <= THR;
    assign cterm = br_a ? e_reg[2] : e_reg[1];
    assign dterm = br_a ? e_reg[1] : e_reg[2];

    assign mat_ridx = (op_reg == OP_FORWARD) ? (4'(i_reg) * 4'd3 + 4'(j_reg))
                                             : (4'(j_reg) * 4'd3 + 4'(i_reg));

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_CMUL:
            begin
                mul_a = 34'(mat_reg[mat_ridx]);
                mul_b = 34'(vin_reg[j_reg]);
            end
            S_SQ:
            begin
                mul_a = wk_t'({2'b00, mag_reg[k_reg]});
                mul_b = wk_t'({2'b00, mag_reg[k_reg]});
            end
            S_CSQ:
            begin
                mul_a = cterm;
                mul_b = cterm;
            end
            S_PMUL:
            begin
                case (k_reg)
                    2'd0:
                    begin
                        mul_a = cterm;
                        mul_b = tb_reg;
                    end
                    2'd1:
                    begin
                        mul_a = cterm;
                        mul_b = ta_reg;
                    end
                    2'd2:
                    begin
                        mul_a = e_reg[0];
                        mul_b = tb_reg;
                    end
                    default:
                    begin
                        mul_a = dterm;
                        mul_b = ta_reg;
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Shared compare-subtract step for square root (two bits) and divide (one bit).
    always_comb
    begin
        if (state_reg == S_SQRT)
        begin
            step_rs = {rem_reg[63:0], num_reg[63:62]};
            step_op = 66'({quo_reg, 2'b01});
        end
        else
        begin
            step_rs = {rem_reg[64:0], num_reg[63]};
            step_op = 66'(den_reg);
        end
        step_diff = {1'b0, step_rs} - {1'b0, step_op};
        step_fit  = !step_diff[66];
    end

    always_comb
    begin
        logic [63:0] nval;
        logic [33:0] qabs;
        wk_t         qs;
        wk_t         aterm;
        acc_t        rnd;
        acc_t        csum;

        state_next  = state_reg;
        ret_next    = ret_reg;
        op_next     = op_reg;
        vin_next    = vin_reg;
        mag_next    = mag_reg;
        e_next      = e_reg;
        ta_next     = ta_reg;
        tb_next     = tb_reg;
        res_next    = res_reg;
        stat_next   = stat_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        acc_next    = acc_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        den_next    = den_reg;
        cnt_next    = cnt_reg;
        oz_next     = oz_reg;
        oy_next     = oy_reg;
        ox_next     = ox_reg;
        ostat_next  = ostat_reg;
        ovalid_next = ovalid_reg && result_stall;
        mat_we      = 1'b0;
        mat_wa      = '0;
        mat_wd      = '0;
        nval        = '0;
        qabs        = {2'b00, quo_reg};
        qs          = '0;
        aterm       = (k_reg == 2'd0) ? dterm : e_reg[0];
        rnd         = (70'(prod_reg) + HALF_M) >>> MAT_FRAC_BITS;
        csum        = acc_reg + 70'(prod_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    op_next     = operation;
                    vin_next[0] = vec_z;
                    vin_next[1] = vec_y;
                    vin_next[2] = vec_x;
                    i_next      = '0;
                    j_next      = '0;
                    k_next      = '0;
                    acc_next    = '0;
                    state_next  = (operation == OP_BUILD) ? S_ABS : S_CMUL;
                end
            end
            S_CMUL:
            begin
                state_next = S_CACC;
            end
            S_CACC:
            begin
                if (j_reg == 2'd2)
                begin
                    res_next[i_reg] = sat32((csum + HALF_M) >>> MAT_FRAC_BITS);
                    acc_next = '0;
                    j_next   = '0;
                    if (i_reg == 2'd2)
                    begin
                        stat_next  = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        i_next     = i_reg + 2'd1;
                        state_next = S_CMUL;
                    end
                end
                else
                begin
                    acc_next   = csum;
                    j_next     = j_reg + 2'd1;
                    state_next = S_CMUL;
                end
            end
            S_ABS:
            begin
                for (int n = 0; n < 3; n++)
                begin
                    mag_next[n] = vin_reg[n][31] ? 32'(-33'(vin_reg[n]))
                                                 : 32'(vin_reg[n]);
                end
                if (vin_reg[0] == '0 && vin_reg[1] == '0 && vin_reg[2] == '0)
                begin
                    res_next[0] = '0;
                    res_next[1] = '0;
                    res_next[2] = '0;
                    stat_next   = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                // Shift until the largest magnitude reaches 2^30.
                if ((mag_reg[0][31:30] | mag_reg[1][31:30] | mag_reg[2][31:30]) == 2'b00)
                begin
                    for (int n = 0; n < 3; n++)
                    begin
                        mag_next[n] = mag_reg[n] << 1;
                    end
                end
                else
                begin
                    k_next     = '0;
                    acc_next   = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                state_next = S_SQACC;
            end
            S_SQACC:
            begin
                if (k_reg == 2'd2)
                begin
                    num_next   = csum[63:0];
                    rem_next   = '0;
                    quo_next   = '0;
                    cnt_next   = 5'd31;
                    ret_next   = S_RSAVE;
                    state_next = S_SQRT;
                end
                else
                begin
                    acc_next   = csum;
                    k_next     = k_reg + 2'd1;
                    state_next = S_SQ;
                end
            end
            S_SQRT:
            begin
                rem_next = step_fit ? step_diff[65:0] : step_rs;
                quo_next = {quo_reg[30:0], step_fit};
                num_next = num_reg << 2;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    state_next = ret_reg;
                end
            end
            S_DIV:
            begin
                rem_next = step_fit ? step_diff[65:0] : step_rs;
                quo_next = {quo_reg[30:0], step_fit};
                num_next = num_reg << 1;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    state_next = ret_reg;
                end
            end
            S_RSAVE:
            begin
                den_next   = quo_reg;
                k_next     = '0;
                state_next = S_ESTART;
            end
            S_ESTART:
            begin
                nval       = (64'(mag_reg[k_reg]) << MAT_FRAC_BITS) + 64'(den_reg >> 1);
                rem_next   = 66'(nval[63:32]);
                num_next   = {nval[31:0], 32'd0};
                quo_next   = '0;
                cnt_next   = 5'd31;
                ret_next   = S_ESAVE;
                state_next = S_DIV;
            end
            S_ESAVE:
            begin
                qs = vin_reg[k_reg][31] ? -wk_t'(qabs) : wk_t'(qabs);
                e_next[k_reg] = qs;
                mat_we = 1'b1;
                mat_wa = 4'(k_reg);
                mat_wd = clamp_m(70'(qs));
                if (k_reg == 2'd2)
                begin
                    state_next = S_CSQ;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_ESTART;
                end
            end
            S_CSQ:
            begin
                state_next = S_QROOT;
            end
            S_QROOT:
            begin
                num_next   = ONE2 - 64'(prod_reg);
                rem_next   = '0;
                quo_next   = '0;
                cnt_next   = 5'd31;
                ret_next   = S_R2SAVE;
                state_next = S_SQRT;
            end
            S_R2SAVE:
            begin
                den_next   = (quo_reg == '0) ? 32'd1 : quo_reg;
                mat_we     = 1'b1;
                mat_wa     = br_a ? 4'd5 : 4'd7;
                mat_wd     = '0;
                k_next     = '0;
                state_next = S_TSTART;
            end
            S_TSTART:
            begin
                nval       = (64'(abs_wk(aterm)) << MAT_FRAC_BITS) + 64'(den_reg >> 1);
                rem_next   = 66'(nval[63:32]);
                num_next   = {nval[31:0], 32'd0};
                quo_next   = '0;
                cnt_next   = 5'd31;
                ret_next   = S_TSAVE;
                state_next = S_DIV;
            end
            S_TSAVE:
            begin
                qs     = aterm[33] ? -wk_t'(qabs) : wk_t'(qabs);
                mat_we = 1'b1;
                if (k_reg == 2'd0)
                begin
                    ta_next = -qs;
                    mat_wa  = br_a ? 4'd3 : 4'd6;
                    mat_wd  = clamp_m(-70'(qs));
                    k_next  = 2'd1;
                    state_next = S_TSTART;
                end
                else
                begin
                    tb_next = qs;
                    mat_wa  = br_a ? 4'd4 : 4'd8;
                    mat_wd  = clamp_m(70'(qs));
                    k_next  = '0;
                    state_next = S_PMUL;
                end
            end
            S_PMUL:
            begin
                state_next = S_PRND;
            end
            S_PRND:
            begin
                state_next = S_PMUL;
                k_next     = k_reg + 2'd1;
                case (k_reg)
                    2'd0:
                    begin
                        mat_we = 1'b1;
                        mat_wa = br_a ? 4'd6 : 4'd3;
                        mat_wd = clamp_m(-rnd);
                    end
                    2'd1:
                    begin
                        mat_we = 1'b1;
                        mat_wa = br_a ? 4'd7 : 4'd5;
                        mat_wd = clamp_m(rnd);
                    end
                    2'd2:
                    begin
                        acc_next = rnd;
                    end
                    default:
                    begin
                        mat_we = 1'b1;
                        mat_wa = br_a ? 4'd8 : 4'd4;
                        mat_wd = clamp_m(acc_reg - rnd);
                        for (int n = 0; n < 3; n++)
                        begin
                            res_next[n] = to_vec(e_reg[n]);
                        end
                        stat_next  = 1'b0;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_DONE:
            begin
                if (!ovalid_reg || !result_stall)
                begin
                    oz_next     = res_reg[0];
                    oy_next     = res_reg[1];
                    ox_next     = res_reg[2];
                    ostat_next  = stat_reg;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_IDLE;
            ovalid_reg <= 1'b0;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            ovalid_reg <= ovalid_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        vin_reg   <= vin_next;
        mag_reg   <= mag_next;
        e_reg     <= e_next;
        ta_reg    <= ta_next;
        tb_reg    <= tb_next;
        res_reg   <= res_next;
        stat_reg  <= stat_next;
        acc_reg   <= acc_next;
        prod_reg  <= mul_a * mul_b;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        den_reg   <= den_next;
        oz_reg    <= oz_next;
        oy_reg    <= oy_next;
        ox_reg    <= ox_next;
        ostat_reg <= ostat_next;
    end

    // Matrix rows, undefined until the first successful build.
    always_ff @(posedge clk)
    begin
        if (mat_we)
        begin
            mat_reg[mat_wa] <= mat_wd;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = ovalid_reg;
    assign out_z        = oz_reg;
    assign out_y        = oy_reg;
    assign out_x        = ox_reg;
    assign status       = ostat_reg;

endmodule

### tb/frame_transform_3d_test.sv
// ----------------------------------------------------------------------------
// Frame transform testbench
// Drives build, forward and inverse items with random idle gaps and output
// stalls, predicts each result in fixed point and checks it field by field.
// ----------------------------------------------------------------------------
module frame_transform_3d_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ft3d_pkg::*;

    localparam int  MAT_FB      = 30;
    localparam int  VEC_FB      = 20;
    localparam int  CYCLE_LIMIT = 1500000;
    localparam logic [31:0] VMAX = 32'h7fffffff;
    localparam logic [31:0] VMIN = 32'h80000000;
    // The fourth operation code behaves as an inverse convert.
    localparam op_t OP_INVERSE_ALT = 2'd3;

    typedef struct {
        op_t  op;
        vec_t z;
        vec_t y;
        vec_t x;
    } frame_item_t;

    typedef struct {
        vec_t z;
        vec_t y;
        vec_t x;
        logic st;
    } frame_result_t;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    op_t  operation;
    vec_t vec_z;
    vec_t vec_y;
    vec_t vec_x;
    logic result_valid;
    logic result_stall;
    vec_t out_z;
    vec_t out_y;
    vec_t out_x;
    logic status;

    frame_item_t   pending_items[$];
    frame_result_t expected_results[$];
    logic signed [31:0] frame_rows[9];
    int   mismatches;
    int   cycle_count;
    int   send_gap;
    int   stall_left;
    int   items_queued;
    int   results_checked;
    logic item_taken;
    bit   built;

    frame_transform_3d u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .operation    (operation),
        .vec_z        (vec_z),
        .vec_y        (vec_y),
        .vec_x        (vec_x),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_z        (out_z),
        .out_y        (out_y),
        .out_x        (out_x),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------- arithmetic

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000000000000000;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint round_shift(longint p, int sh);
        if (sh <= 0) return p;
        return (p + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint div_round(longint num, longint unsigned den);
        longint unsigned mag;
        if (den == 0) den = 1;
        mag = ((num < 0) ? longint'(-num) : num);
        mag = (mag + den / 2) / den;
        return (num < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint mul_q(longint a, longint b);
        return round_shift(a * b, MAT_FB);
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clamp_unit(longint v);
        longint one;
        one = 64'sd1 <<< MAT_FB;
        if (v > one) return one;
        if (v < -one) return -one;
        return v;
    endfunction

    function automatic longint recip_root_term(longint a, longint c);
        longint unsigned q;
        longint unsigned r2;
        q  = (64'd1 << (2 * MAT_FB)) - longint'(c * c);
        r2 = int_sqrt(q);
        return div_round(a * (64'sd1 <<< MAT_FB), r2);
    endfunction

    // Computes the result of one item and updates the frame on a build.
    function automatic frame_result_t frame_step(frame_item_t it);
        frame_result_t   res;
        longint          v[3];
        longint          e[3];
        longint          t[9];
        longint          acc;
        longint          mv;
        longint unsigned mag[3];
        longint unsigned m;
        longint unsigned s;
        longint unsigned r;
        longint unsigned thr;
        longint unsigned ax;
        longint          o[3];
        v[0] = longint'(it.z);
        v[1] = longint'(it.y);
        v[2] = longint'(it.x);
        res.st = 1'b0;
        if (it.op == OP_BUILD)
        begin
            m = 0;
            for (int i = 0; i < 3; i++)
            begin
                mag[i] = (v[i] < 0) ? longint'(-v[i]) : v[i];
                if (mag[i] > m) m = mag[i];
            end
            if (m == 0)
            begin
                res.z = '0;
                res.y = '0;
                res.x = '0;
                res.st = 1'b1;
                return res;
            end
            while (m < (64'd1 << 30))
            begin
                m = m << 1;
                for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
            end
            s = 0;
            for (int i = 0; i < 3; i++) s = s + mag[i] * mag[i];
            r = int_sqrt(s);
            if (r == 0) r = 1;
            for (int i = 0; i < 3; i++)
            begin
                e[i] = ((mag[i] << MAT_FB) + r / 2) / r;
                if (v[i] < 0) e[i] = -e[i];
            end
            thr = (64'd4 << MAT_FB) / 5;
            ax  = (e[2] < 0) ? longint'(-e[2]) : e[2];
            t[0] = e[0];
            t[1] = e[1];
            t[2] = e[2];
            if (ax <= thr)
            begin
                t[3] = -recip_root_term(e[1], e[2]);
                t[4] = recip_root_term(e[0], e[2]);
                t[5] = 0;
                t[6] = -mul_q(t[2], t[4]);
                t[7] = mul_q(t[2], t[3]);
                t[8] = mul_q(t[0], t[4]) - mul_q(t[1], t[3]);
            end
            else
            begin
                t[6] = -recip_root_term(e[2], e[1]);
                t[7] = 0;
                t[8] = recip_root_term(e[0], e[1]);
                t[3] = -mul_q(t[1], t[8]);
                t[4] = mul_q(t[0], t[8]) - mul_q(t[2], t[6]);
                t[5] = mul_q(t[1], t[6]);
            end
            for (int i = 0; i < 9; i++) frame_rows[i] = 32'(clamp_unit(t[i]));
            for (int i = 0; i < 3; i++) o[i] = sat32(round_shift(e[i], MAT_FB - VEC_FB));
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc = 0;
                for (int j = 0; j < 3; j++)
                begin
                    mv = (it.op == OP_FORWARD) ? longint'(frame_rows[i * 3 + j])
                                               : longint'(frame_rows[j * 3 + i]);
                    acc = acc + mv * v[j];
                end
                o[i] = sat32(round_shift(acc, MAT_FB));
            end
        end
        res.z = vec_t'(o[0]);
        res.y = vec_t'(o[1]);
        res.x = vec_t'(o[2]);
        return res;
    endfunction

    // ---------------------------------------------------------------- stimulus

    // Component with a spread of magnitudes, so small axes exercise the
    // normalizing shift and large ones the saturation of converts.
    function automatic vec_t random_component();
        int pick;
        logic [31:0] mag;
        pick = $urandom_range(0, 19);
        if (pick == 0) return '0;
        if (pick == 1) return VMAX;
        if (pick == 2) return VMIN;
        mag = $urandom >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? -vec_t'(mag) : vec_t'(mag);
    endfunction

    task automatic queue_item(op_t op, vec_t z, vec_t y, vec_t x);
        frame_item_t it;
        it.op = op;
        it.z  = z;
        it.y  = y;
        it.x  = x;
        if (op == OP_BUILD && (z != 0 || y != 0 || x != 0)) built = 1'b1;
        pending_items.push_back(it);
        items_queued++;
    endtask

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on %s: got %0d expected %0d", field, got, want);
        mismatches++;
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_taken <= 1'b0;
        else
            item_taken <= item_valid && !item_stall;
    end

    always @(posedge clk)
    begin
        frame_item_t it;
        if (rst_n && item_valid && !item_stall)
        begin
            it.op = operation;
            it.z  = vec_z;
            it.y  = vec_y;
            it.x  = vec_x;
            expected_results.push_back(frame_step(it));
        end
    end

    always @(negedge clk)
    begin
        frame_item_t it;
        if (!rst_n)
            item_valid <= 1'b0;
        else if (!item_valid || item_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                item_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                it = pending_items.pop_front();
                operation  <= it.op;
                vec_z      <= it.z;
                vec_y      <= it.y;
                vec_x      <= it.x;
                item_valid <= 1'b1;
                send_gap   = pick_gap();
            end
            else
                item_valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            stall_left = pick_gap();
            result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("result with no item outstanding");
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (out_z !== want.z) report_mismatch("out_z", out_z, want.z);
                if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
                if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
                if (status !== want.st) report_mismatch("status", status, want.st);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        int pick;
        rst_n           = 1'b0;
        item_valid      = 1'b0;
        result_stall    = 1'b0;
        operation       = OP_BUILD;
        vec_z           = '0;
        vec_y           = '0;
        vec_x           = '0;
        mismatches      = 0;
        cycle_count     = 0;
        send_gap        = 0;
        stall_left      = 0;
        items_queued    = 0;
        results_checked = 0;
        built           = 1'b0;

        // Directed: tiny and extreme axes, both branches, a zero axis, and
        // converts at the field extremes including the unnamed fourth code.
        queue_item(OP_BUILD, 32'sd1, 32'sd0, 32'sd0);
        queue_item(OP_FORWARD, VMAX, VMIN, VMAX);
        queue_item(OP_INVERSE, VMIN, VMAX, VMIN);
        queue_item(OP_BUILD, 32'sd0, 32'sd0, 32'sd0);
        queue_item(OP_FORWARD, 32'sd1048576, 32'sd0, 32'sd0);
        queue_item(OP_BUILD, VMIN, VMIN, VMIN);
        queue_item(OP_FORWARD, 32'sd1048576, 32'sd2097152, -32'sd3145728);
        queue_item(OP_INVERSE_ALT, 32'sd1048576, 32'sd2097152, -32'sd3145728);
        queue_item(OP_BUILD, 32'sd1, 32'sd2, VMAX);
        queue_item(OP_INVERSE, VMAX, VMAX, VMAX);
        queue_item(OP_FORWARD, -32'sd1, 32'sd1, 32'sd0);
        queue_item(OP_BUILD, 32'sd3, -32'sd4, 32'sd4);
        queue_item(OP_FORWARD, VMIN, VMIN, VMIN);
        queue_item(OP_INVERSE_ALT, VMAX, 32'sd0, VMIN);
        queue_item(OP_BUILD, VMAX, VMIN, 32'sd0);
        queue_item(OP_INVERSE, 32'sd0, 32'sd0, 32'sd0);
        queue_item(OP_BUILD, 32'sd0, 32'sd0, VMIN);
        queue_item(OP_FORWARD, 32'sd12345, -32'sd67890, 32'sd424242);

        for (int n = 0; n < 600; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15 || !built)
            begin
                if (pick < 2)
                    queue_item(OP_BUILD, '0, '0, '0);
                else
                    queue_item(OP_BUILD, random_component(), random_component(),
                               random_component());
            end
            else
                queue_item(op_t'($urandom_range(1, 3)), random_component(),
                           random_component(), random_component());
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Every queued item has produced its checked result.
        wait (results_checked == items_queued);
        repeat (300) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
design/ft3d_pkg.sv
design/frame_transform_3d.sv
tb/frame_transform_3d_test.sv
